// File: sv/mqrm_pkg.sv
// Shared types and codes for the multi-queue ring manager.
// Used by the controller, the datapath and the top level; depends on nothing.
package mqrm_pkg;

    // Default geometry: number of queues and slots per queue.
    localparam int QUEUES_DEF = 8;
    localparam int DEPTH_DEF  = 16;

    // Request modes.
    localparam logic [1:0] MODE_ALLOC   = 2'd0;
    localparam logic [1:0] MODE_PUSH    = 2'd1;
    localparam logic [1:0] MODE_POP     = 2'd2;
    localparam logic [1:0] MODE_RELEASE = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_INVALID    = 3'd1;
    localparam logic [2:0] ST_NOT_IN_USE = 3'd2;
    localparam logic [2:0] ST_EMPTY      = 3'd3;
    localparam logic [2:0] ST_FULL       = 3'd4;
    localparam logic [2:0] ST_NO_FREE    = 3'd5;

    // One request item.
    typedef struct packed {
        logic [1:0]         mode;
        logic [3:0]         queue_id;
        logic signed [31:0] element_id;
        logic [63:0]        payload_ref;
    } req_t;

    // One result item.
    typedef struct packed {
        logic [2:0]         status;
        logic [3:0]         granted_queue;
        logic signed [31:0] popped_id;
        logic [63:0]        popped_payload;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the incoming request
        logic exec;     // decide and update queue state
        logic pop_out;  // deliver the entry read from the store
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pop_read; // the current request is a pop that reads the store
    } sts_t;

endpackage

// File: sv/mqrm_ctrl.sv
// Controller state machine of the multi-queue ring manager.
// Depends on mqrm_pkg for the command and status structs.
module mqrm_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  mqrm_pkg::sts_t sts,
    output mqrm_pkg::cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_POPOUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;

    // Next state and registered busy flag.
    always_comb
    begin
        state_next = state_reg;
        busy_next  = busy_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                    busy_next  = 1'b1;
                end
            end
            S_EXEC:
            begin
                if (sts.pop_read)
                begin
                    state_next = S_POPOUT;
                end
                else
                begin
                    state_next = S_IDLE;
                    busy_next  = 1'b0;
                end
            end
            S_POPOUT:
            begin
                state_next = S_IDLE;
                busy_next  = 1'b0;
            end
            default:
            begin
                state_next = S_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    // State register and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    // Commands decoded from the state.
    always_comb
    begin
        cmd.load    = (state_reg == S_IDLE) && start;
        cmd.exec    = (state_reg == S_EXEC);
        cmd.pop_out = (state_reg == S_POPOUT);
    end

    assign busy = busy_reg;

endmodule

// File: sv/mqrm_dpath.sv
// Datapath of the multi-queue ring manager: queue flags, pointers, shared store.
// Depends on mqrm_pkg for item types, codes and the command and status structs.
module mqrm_dpath #(
    parameter int QUEUES = mqrm_pkg::QUEUES_DEF,
    parameter int DEPTH  = mqrm_pkg::DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  mqrm_pkg::req_t request,
    input  mqrm_pkg::cmd_t cmd,
    output mqrm_pkg::sts_t sts,
    output logic           done,
    output mqrm_pkg::rsp_t result
);

    localparam int QW     = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int SLOTS  = QUEUES * DEPTH;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef struct packed {
        logic signed [31:0] element_id;
        logic [63:0]        payload_ref;
    } entry_t;

    mqrm_pkg::req_t   req_reg;
    logic             active_reg [QUEUES];
    logic [PTR_W-1:0] wptr_reg [QUEUES];
    logic [PTR_W-1:0] rptr_reg [QUEUES];
    mqrm_pkg::rsp_t   rsp_reg;
    logic             done_reg;
    entry_t           mem [SLOTS];
    entry_t           rd_data_reg;

    logic [QW-1:0]     qidx;
    logic              q_valid;
    logic              found;
    logic [QW-1:0]     free_idx;
    logic [PTR_W-1:0]  wptr;
    logic [PTR_W-1:0]  rptr;
    logic [PTR_W-1:0]  wptr_adv;
    logic [PTR_W-1:0]  rptr_adv;
    logic [SLOT_W-1:0] slot;
    logic [2:0]        st;
    logic              wr_en;
    logic              rd_en;
    logic              act_set;
    logic              act_clr;

    // Capture the request item when the controller accepts it.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= request;
        end
    end

    assign qidx     = req_reg.queue_id[QW-1:0];
    assign q_valid  = ({1'b0, req_reg.queue_id} < 5'(QUEUES));
    assign wptr     = wptr_reg[qidx];
    assign rptr     = rptr_reg[qidx];
    assign wptr_adv = (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
    assign rptr_adv = (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;

    // Lowest-numbered free queue.
    always_comb
    begin
        found    = 1'b0;
        free_idx = '0;
        for (int i = QUEUES - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                found    = 1'b1;
                free_idx = QW'(i);
            end
        end
    end

    // Slot of the queue's write or read position in the shared store.
    assign slot = SLOT_W'(qidx) * SLOT_W'(DEPTH)
                + SLOT_W'((req_reg.mode == mqrm_pkg::MODE_PUSH) ? wptr : rptr);

    // Decide the outcome of the held request.
    always_comb
    begin
        st      = mqrm_pkg::ST_OK;
        wr_en   = 1'b0;
        rd_en   = 1'b0;
        act_set = 1'b0;
        act_clr = 1'b0;
        if (req_reg.mode == mqrm_pkg::MODE_ALLOC)
        begin
            if (found)
            begin
                act_set = 1'b1;
            end
            else
            begin
                st = mqrm_pkg::ST_NO_FREE;
            end
        end
        else if (!q_valid)
        begin
            st = mqrm_pkg::ST_INVALID;
        end
        else if (req_reg.mode == mqrm_pkg::MODE_RELEASE)
        begin
            act_clr = 1'b1;
        end
        else if (!active_reg[qidx])
        begin
            st = mqrm_pkg::ST_NOT_IN_USE;
        end
        else if (req_reg.mode == mqrm_pkg::MODE_PUSH)
        begin
            if (wptr_adv == rptr)
            begin
                st = mqrm_pkg::ST_FULL;
            end
            else
            begin
                wr_en = 1'b1;
            end
        end
        else
        begin
            if (rptr == wptr)
            begin
                st = mqrm_pkg::ST_EMPTY;
            end
            else
            begin
                rd_en = 1'b1;
            end
        end
    end

    assign sts.pop_read = rd_en;

    // Queue flags, pointers and the result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QUEUES; i++)
            begin
                active_reg[i] <= 1'b0;
                wptr_reg[i]   <= '0;
                rptr_reg[i]   <= '0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                if (act_set)
                begin
                    active_reg[free_idx] <= 1'b1;
                end
                if (act_clr)
                begin
                    active_reg[qidx] <= 1'b0;
                end
                if (wr_en)
                begin
                    wptr_reg[qidx] <= wptr_adv;
                end
                if (rd_en)
                begin
                    rptr_reg[qidx] <= rptr_adv;
                end
            end
            done_reg <= (cmd.exec && !rd_en) || cmd.pop_out;
        end
    end

    // Result fields; a pop result waits for the registered store read.
    always_ff @(posedge clk)
    begin
        if (cmd.exec && !rd_en)
        begin
            rsp_reg.status         <= st;
            rsp_reg.granted_queue  <= act_set ? 4'(free_idx) : 4'd0;
            rsp_reg.popped_id      <= '0;
            rsp_reg.popped_payload <= '0;
        end
        else if (cmd.pop_out)
        begin
            rsp_reg.status         <= mqrm_pkg::ST_OK;
            rsp_reg.granted_queue  <= 4'd0;
            rsp_reg.popped_id      <= rd_data_reg.element_id;
            rsp_reg.popped_payload <= rd_data_reg.payload_ref;
        end
    end

    // Shared entry store with a registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
        begin
            mem[slot] <= '{element_id: req_reg.element_id, payload_ref: req_reg.payload_ref};
        end
        if (cmd.exec && rd_en)
        begin
            rd_data_reg <= mem[slot];
        end
    end

    assign done   = done_reg;
    assign result = rsp_reg;

endmodule

// File: sv/multi_queue_ring_manager_core.sv
// Top level of the multi-queue ring manager: controller plus datapath.
// Depends on mqrm_pkg, mqrm_ctrl and mqrm_dpath.
//
// Usage: QUEUES ring FIFOs of DEPTH slots each share one entry store; a queue
// holds at most DEPTH-1 entries. A request item (allocate, push, pop, release)
// is presented on the request port and accepted at a rising edge where start
// is high and busy is low. Busy rises the cycle after acceptance.
// Each item produces exactly one result item on the result port, marked by a
// one-cycle done strobe; the receiver cannot stall, so it must take the result
// in that cycle.
// Sequence: allocate, push, release and failed pops register their result from
// the execute state; a successful pop also passes through the registered read
// of the entry store and a pop-output state. The next item can be accepted in
// the cycle the result appears; the controller handles one item at a time.
// Reset (rst_n low, asynchronous) frees all queues and clears all pointers;
// the entry store is not cleared and needs no clearing pass.
module multi_queue_ring_manager_core #(
    parameter int QUEUES = mqrm_pkg::QUEUES_DEF,
    parameter int DEPTH  = mqrm_pkg::DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  mqrm_pkg::req_t request,
    output logic           done,
    output mqrm_pkg::rsp_t result
);

    mqrm_pkg::cmd_t cmd;
    mqrm_pkg::sts_t sts;

    // Sequencing of one item.
    mqrm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    // Queue state and the shared store.
    mqrm_dpath #(
        .QUEUES (QUEUES),
        .DEPTH  (DEPTH)
    ) u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .sts     (sts),
        .done    (done),
        .result  (result)
    );

    // An accepted item makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted item");

    // Results never come in consecutive cycles, one per item.
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done strobe held for more than one cycle");

    // A failed request returns no popped data and no granted queue.
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != mqrm_pkg::ST_OK) |->
        (result.popped_id == 32'sd0 && result.popped_payload == 64'd0
         && result.granted_queue == 4'd0))
        else $error("failed request returned data");

    // A result only follows work the controller was doing.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without an item in progress");

endmodule
